// ----- rtl/pcmf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcmf_pkg
// Shared types, register map and a reset value for the PCM to float block.
// ----------------------------------------------------------------------------
package pcmf_pkg;

  localparam int unsigned RawW = 64;
  localparam int unsigned OutW = 32;
  localparam int unsigned AddrW = 4;

  localparam logic [1:0] REG_SAMPLE_BYTES = 2'd0;
  localparam logic [1:0] REG_FLOAT_FORMAT = 2'd1;
  localparam logic [1:0] REG_BIG_ENDIAN = 2'd2;
  localparam logic [1:0] REG_UNSIGNED_8BIT = 2'd3;

  localparam logic [3:0] SampleBytesRst = 4'd2;

  typedef struct packed {
    logic [3:0] sample_bytes;
    logic       float_format;
    logic       big_endian;
    logic       unsigned_8bit;
  } cfg_t;

endpackage
`default_nettype wire

// ----- rtl/pcmf_regs.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcmf_regs
// APB-style configuration registers.
// ----------------------------------------------------------------------------
module pcmf_regs (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [pcmf_pkg::AddrW-1:0]  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  output pcmf_pkg::cfg_t                   cfg
);

  logic       wr;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;
  assign idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sample_bytes <= pcmf_pkg::SampleBytesRst;
      cfg.float_format <= 1'b0;
      cfg.big_endian <= 1'b0;
      cfg.unsigned_8bit <= 1'b1;
    end else if (wr) begin
      case (idx)
        pcmf_pkg::REG_SAMPLE_BYTES: cfg.sample_bytes <= pwdata[3:0];
        pcmf_pkg::REG_FLOAT_FORMAT: cfg.float_format <= pwdata[0];
        pcmf_pkg::REG_BIG_ENDIAN: cfg.big_endian <= pwdata[0];
        pcmf_pkg::REG_UNSIGNED_8BIT: cfg.unsigned_8bit <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      pcmf_pkg::REG_SAMPLE_BYTES: prdata[3:0] = cfg.sample_bytes;
      pcmf_pkg::REG_FLOAT_FORMAT: prdata[0] = cfg.float_format;
      pcmf_pkg::REG_BIG_ENDIAN: prdata[0] = cfg.big_endian;
      pcmf_pkg::REG_UNSIGNED_8BIT: prdata[0] = cfg.unsigned_8bit;
      default: prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/pcmf_conv.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcmf_conv
// Combinational reordering and conversion of one sample to a float32 pattern.
// ----------------------------------------------------------------------------
module pcmf_conv (
  input  wire logic [63:0]   raw,
  input  pcmf_pkg::cfg_t     cfg,
  output logic [31:0]        bits,
  output logic               err
);

  logic [63:0] v;
  logic        ok;
  logic        neg;
  logic [31:0] mag;
  logic [5:0]  top;
  logic [31:0] norm;
  logic [8:0]  iexp;
  logic [23:0] im;
  logic        rup;
  logic [24:0] ir;
  logic [31:0] ibits;
  logic [31:0] fbits;

  // double path
  logic        dn;
  logic [10:0] dex;
  logic [51:0] dfr;
  logic [52:0] dm;
  logic signed [12:0] e;
  logic signed [12:0] sh;
  logic [55:0] dsh;
  logic        sticky;
  logic [23:0] dq;
  logic        drup;
  logic [30:0] dsum;

  always_comb begin
    v = '0;
    for (int i = 0; i < 8; i++) begin
      if (i < cfg.sample_bytes) begin
        if (cfg.big_endian) begin
          v[8*(cfg.sample_bytes-1-4'(i))+:8] = raw[8*i+:8];
        end else begin
          v[8*i+:8] = raw[8*i+:8];
        end
      end
    end
  end

  assign ok = cfg.float_format ? (cfg.sample_bytes == 4'd4 || cfg.sample_bytes == 4'd8)
                               : (cfg.sample_bytes >= 4'd1 && cfg.sample_bytes <= 4'd4);

  // integer: value left-justified to 32 bits, magnitude then normalized
  always_comb begin
    logic [31:0] j;
    j = v[31:0] << (6'd32 - {cfg.sample_bytes[2:0], 3'b000});
    if (cfg.sample_bytes == 4'd1 && cfg.unsigned_8bit) begin
      j = {~v[7], v[6:0], 24'd0};
    end
    neg = j[31];
    mag = neg ? (32'd0 - j) : j;
    top = 6'd0;
    for (int k = 0; k < 32; k++) begin
      if (mag[k]) top = 6'(k);
    end
    norm = mag << (6'd31 - top);
    rup = norm[7] && (norm[6:0] != 0 || norm[8]);
    ir = {1'b0, norm[31:8]} + 25'(rup);
    // value = mag * 2^-31, exponent = top - 31 + 127
    iexp = 9'(top) + 9'd96 + 9'(ir[24]);
    im = ir[24] ? 24'd0 : ir[23:0];
    ibits = (mag == 0) ? {neg, 31'd0} : {neg, iexp[7:0], im[22:0]};
  end

  always_comb begin
    dn = v[63];
    dex = v[62:52];
    dfr = v[51:0];
    dm = {(dex != 0), dfr};
    // single biased exponent
    e = 13'(dex) - 13'sd896;
    sh = 13'sd29 + ((e < 13'sd1) ? (13'sd1 - e) : 13'sd0);
    if (dex == 0) sh = 13'sd62;
    dsh = '0;
    sticky = 1'b0;
    if (sh > 13'sd55) begin
      sticky = (dm != 0);
    end else begin
      dsh = {dm, 3'b000} >> sh[5:0];
      sticky = (({dm, 3'b000} & ((56'd1 << sh[5:0]) - 56'd1)) != 0);
    end
    // dsh holds q in [26:3], guard bit [2]
    dq = dsh[26:3];
    drup = dsh[2] && (dsh[1] || dsh[0] || sticky || dq[0]);
    dsum = {((e < 13'sd1) ? 8'd0 : e[7:0]), 23'd0} + 31'(dq) + 31'(drup)
           - ((e < 13'sd1) ? 31'd0 : 31'h0080_0000);
    if (dex == 11'h7FF) begin
      fbits = (dfr == 0) ? {dn, 31'h7F800000} : {dn, 9'h1FF, dfr[50:29]};
    end else if (dex == 0) begin
      fbits = {dn, 31'd0};
    end else if (e > 13'sd254) begin
      fbits = {dn, 31'h7F800000};
    end else if (dsum >= 31'h7F800000) begin
      fbits = {dn, 31'h7F800000};
    end else begin
      fbits = {dn, dsum};
    end
    if (cfg.sample_bytes == 4'd4) fbits = v[31:0];
  end

  assign err = !ok;
  assign bits = !ok ? 32'd0 : (cfg.float_format ? fbits : ibits);

endmodule
`default_nettype wire

// ----- rtl/pcm_sample_to_float.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcm_sample_to_float
// Raw PCM sample to IEEE single-precision converter.
// ----------------------------------------------------------------------------
// One beat in, one beat out. The input register feeds a single combinational
// conversion stage into the output register, so a beat is taken every cycle
// unless a stalled output register holds it back; the result passes each
// register in turn. Either register moves when the stage after it is free.
module pcm_sample_to_float (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [pcmf_pkg::AddrW-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [63:0]                raw_sample,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [31:0]                     sample_bits,
  output logic                            error
);

  pcmf_pkg::cfg_t cfg;
  logic        s1_valid;
  logic [63:0] s1_raw;
  logic        s1_ready;
  logic [31:0] c_bits;
  logic        c_err;

  pcmf_regs u_regs (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
  );

  pcmf_conv u_conv (.raw(s1_raw), .cfg(cfg), .bits(c_bits), .err(c_err));

  assign s1_ready = !out_valid || out_ready;
  assign in_ready = !s1_valid || s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) s1_valid <= in_valid;
      if (s1_ready) out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) s1_raw <= raw_sample;
    if (s1_ready && s1_valid) begin
      sample_bits <= c_bits;
      error <= c_err;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/pcmf_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcmf_checker
// Port-level checks for the converter, bound to the top level.
// ----------------------------------------------------------------------------
module pcmf_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] sample_bits,
  input wire logic        error
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sample_bits))
    else $error("output beat dropped");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && error |-> sample_bits == 32'd0)
    else $error("error beat carries data");

  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("valid after reset");

endmodule

bind pcm_sample_to_float pcmf_checker u_chk (
  .clk(clk), .rst(rst), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready),
  .sample_bits(sample_bits), .error(error)
);
`default_nettype wire

// ----- sim/pcm_sample_to_float_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm_sample_to_float_tb
// Streams raw samples through the converter under many register settings and
// checks each output beat against an in-bench model of the PCM/float64 to
// single-precision conversion, with random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module pcm_sample_to_float_tb;

  localparam int unsigned CycleLimit = 400000;

  typedef struct packed {
    logic [31:0] bits;
    logic        err;
  } conv_t;

  logic                         clk;
  logic                         rst;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [pcmf_pkg::AddrW-1:0]   paddr;
  logic [31:0]                  pwdata;
  logic [31:0]                  prdata;
  logic                         pready;
  logic                         in_valid;
  logic                         in_ready;
  logic [63:0]                  raw_sample;
  logic                         out_valid;
  logic                         out_ready;
  logic [31:0]                  sample_bits;
  logic                         error;

  pcmf_pkg::cfg_t cfg;
  logic [63:0]   pending_q[$];
  conv_t         expected_q[$];
  int unsigned   burst_left;
  int unsigned   gap_left;
  int unsigned   fail_count;
  int unsigned   cycle_count;
  logic [7:0]    stall_lfsr;
  bit            hold_send;

  pcm_sample_to_float u_top (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .raw_sample(raw_sample),
    .out_valid(out_valid), .out_ready(out_ready), .sample_bits(sample_bits),
    .error(error)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // round sign * mag * 2^exp2 to single, nearest even
  function automatic logic [31:0] round_single(bit neg, logic [63:0] mag, int exp2);
    logic [31:0] sgn;
    int top;
    int ex;
    int lsb;
    int sh;
    logic [63:0] q;
    logic [63:0] rem;
    logic [63:0] half;
    logic [31:0] bits;
    sgn = neg ? 32'h8000_0000 : 32'h0;
    if (mag == 0) return sgn;
    top = 63;
    while (!mag[top]) top--;
    ex = top + exp2;
    if (ex > 127) return sgn | 32'h7F80_0000;
    lsb = ex - 23;
    if (lsb < -149) lsb = -149;
    sh = lsb - exp2;
    if (sh <= 0) begin
      q = mag << (-sh);
    end else if (sh >= 62) begin
      q = 0;
    end else begin
      rem = mag & ((64'd1 << sh) - 1);
      half = 64'd1 << (sh - 1);
      q = mag >> sh;
      if (rem > half || (rem == half && q[0])) q++;
    end
    bits = (32'(lsb + 149) << 23) + q[31:0];
    if (bits >= 32'h7F80_0000) bits = 32'h7F80_0000;
    return sgn | bits;
  endfunction

  function automatic logic [31:0] double_to_single(logic [63:0] d);
    logic [10:0] ex;
    logic [51:0] fr;
    ex = d[62:52];
    fr = d[51:0];
    if (ex == 11'h7FF) begin
      if (fr == 0) return {d[63], 31'h7F80_0000};
      return {d[63], 31'h7FC0_0000 | 31'(fr[51:29])};
    end
    if (ex == 0) return round_single(d[63], {12'd0, fr}, -1074);
    return round_single(d[63], {11'd0, 1'b1, fr}, int'(ex) - 1075);
  endfunction

  function automatic conv_t convert_sample(logic [63:0] raw);
    conv_t r;
    int n;
    int width;
    logic [63:0] v;
    logic [63:0] mag;
    bit neg;
    bit ok;
    n = cfg.sample_bytes;
    ok = cfg.float_format ? (n == 4 || n == 8) : (n >= 1 && n <= 4);
    r.err = !ok;
    r.bits = '0;
    if (!ok) return r;
    v = '0;
    for (int i = 0; i < n; i++)
      v[8*(cfg.big_endian ? n - 1 - i : i) +: 8] = raw[8*i +: 8];
    if (cfg.float_format) begin
      r.bits = (n == 4) ? v[31:0] : double_to_single(v);
    end else begin
      width = 8 * n;
      if (n == 1 && cfg.unsigned_8bit) begin
        neg = v < 128;
        mag = neg ? 128 - v : v - 128;
      end else begin
        neg = v[width-1];
        mag = neg ? ((64'd1 << width) - v) : v;
      end
      r.bits = round_single(neg, mag, -(width - 1));
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycle_count);
    fail_count++;
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= pcmf_pkg::AddrW'(idx) << 2;
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      pcmf_pkg::REG_SAMPLE_BYTES: cfg.sample_bytes = val[3:0];
      pcmf_pkg::REG_FLOAT_FORMAT: cfg.float_format = val[0];
      pcmf_pkg::REG_BIG_ENDIAN: cfg.big_endian = val[0];
      default: cfg.unsigned_8bit = val[0];
    endcase
  endtask

  task automatic set_mode(int nbytes, bit fp, bit be, bit u8);
    write_reg(pcmf_pkg::REG_SAMPLE_BYTES, 32'(nbytes));
    write_reg(pcmf_pkg::REG_FLOAT_FORMAT, 32'(fp));
    write_reg(pcmf_pkg::REG_BIG_ENDIAN, 32'(be));
    write_reg(pcmf_pkg::REG_UNSIGNED_8BIT, 32'(u8));
  endtask

  task automatic drain;
    while (pending_q.size() != 0 || in_valid || expected_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  function automatic logic [63:0] rand_raw();
    return {$urandom(), $urandom()};
  endfunction

  // interesting float64 patterns: specials, single range edges, ties
  function automatic logic [63:0] rand_double();
    logic [63:0] d;
    d = rand_raw();
    case ($urandom_range(0, 7))
      0: d[62:52] = 11'h7FF;
      1: d[62:52] = 11'd0;
      2: d[62:52] = 11'($urandom_range(1023 - 155, 1023 - 120));
      3: d[62:52] = 11'($urandom_range(1023 + 120, 1023 + 130));
      4: d[28:0] = {1'b1, 28'd0};
      5: d[62:52] = 11'($urandom_range(1023 - 30, 1023 + 30));
      default: ;
    endcase
    return d;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_q.size() != 0 && !hold_send) begin
          in_valid <= 1'b1;
          raw_sample <= pending_q[0];
          expected_q.push_back(convert_sample(pending_q.pop_front()));
          if (burst_left == 0) begin
            burst_left <= $urandom_range(0, 30);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    conv_t want;
    if (rst) begin
      stall_lfsr <= 8'hA5;
      out_ready <= 1'b0;
    end else begin
      stall_lfsr <= {stall_lfsr[6:0], stall_lfsr[7] ^ stall_lfsr[5] ^ stall_lfsr[4] ^ stall_lfsr[3]};
      out_ready <= stall_lfsr[7] ? 1'b1 : (stall_lfsr[2:0] != 3'd0);
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected beat", sample_bits, 32'd0);
        end else begin
          want = expected_q.pop_front();
          if (sample_bits !== want.bits) report_mismatch("sample_bits", sample_bits, want.bits);
          if (error !== want.err) report_mismatch("error", 32'(error), 32'(want.err));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int modes[12][4];
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    raw_sample = '0;
    out_ready = 1'b0;
    hold_send = 1'b0;
    fail_count = 0;
    cycle_count = 0;
    cfg = '{sample_bytes: pcmf_pkg::SampleBytesRst, float_format: 1'b0, big_endian: 1'b0,
            unsigned_8bit: 1'b1};
    rst = 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: reset mode (16-bit LE) extremes
    pending_q.push_back(64'h0);
    pending_q.push_back(64'h7FFF);
    pending_q.push_back(64'h8000);
    pending_q.push_back(64'hFFFF_FFFF_FFFF_FFFF);
    drain();
    set_mode(1, 0, 0, 1);
    pending_q.push_back(64'h00);
    pending_q.push_back(64'h80);
    pending_q.push_back(64'hFF);
    drain();
    set_mode(1, 0, 1, 0);
    pending_q.push_back(64'h80);
    pending_q.push_back(64'h7F);
    drain();
    set_mode(4, 0, 0, 0);
    pending_q.push_back(64'h7FFF_FFFF);
    pending_q.push_back(64'h8000_0000);
    pending_q.push_back(64'h0100_0001);
    pending_q.push_back(64'h0300_0001);
    drain();
    set_mode(8, 1, 0, 0);
    pending_q.push_back(64'h7FF0_0000_0000_0000);
    pending_q.push_back(64'hFFF8_0000_1234_5678);
    pending_q.push_back(64'h7FF0_0000_0000_0001);
    pending_q.push_back(64'h47F0_0000_0000_0000);
    pending_q.push_back(64'h3690_0000_0000_0000);
    pending_q.push_back(64'h0000_0000_0000_0001);
    pending_q.push_back(64'h3FF0_0000_1000_0000);
    drain();
    set_mode(5, 0, 0, 0);
    pending_q.push_back(64'h1234);
    drain();
    set_mode(15, 1, 1, 1);
    pending_q.push_back(64'h1234);
    drain();

    modes = '{'{1,0,0,1}, '{1,0,1,0}, '{2,0,0,0}, '{2,0,1,1}, '{3,0,0,0},
              '{3,0,1,0}, '{4,0,0,1}, '{4,0,1,0}, '{4,1,1,0}, '{8,1,0,1},
              '{8,1,1,0}, '{6,1,0,0}};
    for (int r = 0; r < 2; r++) begin
      for (int m = 0; m < 12; m++) begin
        set_mode(modes[m][0], modes[m][1], modes[m][2], modes[m][3]);
        for (int k = 0; k < 45; k++)
          pending_q.push_back(modes[m][1] && modes[m][0] == 8 ? rand_double() : rand_raw());
        if (m == 5) begin
          while (pending_q.size() > 20) @(posedge clk);
          hold_send = 1'b1;
          while (in_valid || expected_q.size() != 0) @(posedge clk);
          hold_send = 1'b0;
        end
        drain();
      end
    end
    set_mode($urandom_range(0, 15), $urandom_range(0, 1), 0, 0);
    for (int k = 0; k < 20; k++) pending_q.push_back(rand_raw());
    drain();

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/pcmf_pkg.sv
rtl/pcmf_regs.sv
rtl/pcmf_conv.sv
rtl/pcm_sample_to_float.sv
rtl/pcmf_checker.sv
sim/pcm_sample_to_float_tb.sv
